// ===== design/quaternion_arithmetic_unit_macros.svh =====
// Assertion macros shared by the quaternion arithmetic unit.
// Each check is sampled on the rising edge of clk and is held off while arst_n is low.
`ifndef QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define QAU_ASSERT_IMP(label, ant, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("quaternion unit check failed");
`define QAU_ASSERT_NXT(label, ant, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("quaternion unit check failed");
`else
`define QAU_ASSERT_IMP(label, ant, cons)
`define QAU_ASSERT_NXT(label, ant, cons)
`endif
`endif

// ===== design/qau_pkg.sv =====
`timescale 1ns / 1ps
package qau_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 24;

	// Operand words are widened by one bit so that negating the most negative word is exact.
	localparam int OW   = WORD_BITS + 1;
	localparam int PRW  = 2 * OW;
	localparam int SW   = PRW + 2;
	localparam int NW   = 2 * WORD_BITS + 1;
	localparam int SQW  = 2 * WORD_BITS;
	localparam int NS   = FRAC_BITS + 2;
	localparam int PW   = 2 * WORD_BITS + 2 * FRAC_BITS + 5;
	localparam int QW   = 2 * WORD_BITS + FRAC_BITS + 3;
	localparam int NSQ_BITS = 64;
	localparam int NPAD = (NW > NSQ_BITS) ? NW : NSQ_BITS + 1;
	localparam int LAST = NS + 3;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [OW-1:0]        opnd_t;
	typedef logic signed [PRW-1:0]       prod_t;
	typedef logic signed [SW-1:0]        sum_t;

	localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		ACT_MUL   = 3'd0,
		ACT_ROT   = 3'd1,
		ACT_CONJ  = 3'd2,
		ACT_NORM  = 3'd3,
		ACT_NSQ   = 3'd4,
		ACT_SCALE = 3'd5
	} action_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	// Hamilton product: output lane i sums four terms p[QM_P] * q[QM_Q], negated where QM_N is set.
	localparam logic [1:0] QM_P [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd2, 2'd3},
		'{2'd2, 2'd0, 2'd3, 2'd1},
		'{2'd3, 2'd0, 2'd1, 2'd2}};
	localparam logic [1:0] QM_Q [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd3, 2'd2},
		'{2'd0, 2'd2, 2'd1, 2'd3},
		'{2'd0, 2'd3, 2'd2, 2'd1}};
	localparam logic [3:0] QM_N [4] = '{4'b1110, 4'b1000, 4'b1000, 4'b1000};

	typedef struct packed {
		logic [2:0] action;
		word_t      a_w;
		word_t      a_x;
		word_t      a_y;
		word_t      a_z;
		word_t      b_w;
		word_t      b_x;
		word_t      b_y;
		word_t      b_z;
		word_t      factor;
	} req_item_t;

	typedef struct packed {
		word_t               r_w;
		word_t               r_x;
		word_t               r_y;
		word_t               r_z;
		logic [NSQ_BITS-1:0] norm_sq;
		logic [1:0]          status;
	} rsp_item_t;

	typedef struct packed {
		rsp_item_t item;
		logic      norm;
		logic      zero;
	} stage_t;

	typedef struct packed {
		logic  sat;
		word_t word;
	} wsat_t;

	function automatic opnd_t sx(input word_t v);
		return {v[WORD_BITS-1], v};
	endfunction

	function automatic wsat_t clamp_word(input sum_t v);
		wsat_t r;
		if (v[SW-1:WORD_BITS-1] == {(SW-WORD_BITS+1){v[SW-1]}}) begin
			r.sat  = 1'b0;
			r.word = v[WORD_BITS-1:0];
		end else begin
			r.sat  = 1'b1;
			r.word = v[SW-1] ? WMIN : WMAX;
		end
		return r;
	endfunction

endpackage

// ===== design/qau_req_if.sv =====
`timescale 1ns / 1ps
interface qau_req_if;
	import qau_pkg::*;
	logic      valid;
	logic      ready;
	req_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/qau_rsp_if.sv =====
`timescale 1ns / 1ps
interface qau_rsp_if;
	import qau_pkg::*;
	logic      valid;
	logic      ready;
	rsp_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/qau_lane.sv =====
`timescale 1ns / 1ps
module qau_lane (
	input  logic           clk,
	input  logic           en,
	input  qau_pkg::opnd_t x [4],
	input  qau_pkg::opnd_t y [4],
	input  logic [3:0]     neg,
	output qau_pkg::prod_t prod_s2 [4],
	output qau_pkg::word_t word_s3,
	output logic           sat_s3,
	output qau_pkg::sum_t  sum_s3
);
	import qau_pkg::*;

	logic [3:0] neg_s2;
	sum_t       acc;
	sum_t       rnd;
	sum_t       shf;
	wsat_t      cw;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				prod_s2[k] <= x[k] * y[k];
			end
			neg_s2 <= neg;
		end
	end

	// Exact signed sum of the four terms, then round half up and clamp to a word.
	always_comb begin
		acc = '0;
		for (int k = 0; k < 4; k++) begin
			if (neg_s2[k]) begin
				acc = acc - SW'(prod_s2[k]);
			end else begin
				acc = acc + SW'(prod_s2[k]);
			end
		end
		rnd = acc + $signed(SW'(1) << (FRAC_BITS - 1));
		shf = rnd >>> FRAC_BITS;
		cw  = clamp_word(shf);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s3 <= cw.word;
			sat_s3  <= cw.sat;
			sum_s3  <= acc;
		end
	end

endmodule

// ===== design/qau_norm_lane.sv =====
`timescale 1ns / 1ps
module qau_norm_lane (
	input  logic                   clk,
	input  logic                   en,
	input  logic [qau_pkg::NW-1:0] nsum,
	input  logic [qau_pkg::SQW-1:0] sq,
	input  logic                   sgn,
	output logic [qau_pkg::NS-1:0] t_out,
	output logic                   sgn_out
);
	import qau_pkg::*;

	// One result bit per stage: the largest t with t*t*N <= sq * 2^(2F+2), built from
	// the most significant bit down while keeping t*t*N and t*N as running sums.
	logic [NS-1:0] t_s [1:NS];
	logic [PW-1:0] p_s [1:NS];
	logic [QW-1:0] q_s [1:NS];
	logic [NW-1:0] n_s [1:NS];
	logic [PW-1:0] x_s [1:NS];
	logic          g_s [1:NS];

	for (genvar k = 0; k < NS; k++) begin : g_step
		localparam int B = NS - 1 - k;
		logic [NS-1:0] t_c;
		logic [PW-1:0] p_c;
		logic [QW-1:0] q_c;
		logic [NW-1:0] n_c;
		logic [PW-1:0] x_c;
		logic          g_c;
		logic [PW-1:0] cand;
		logic          take;

		if (k == 0) begin : g_first
			assign t_c = '0;
			assign p_c = '0;
			assign q_c = '0;
			assign n_c = nsum;
			assign x_c = PW'(sq) << (2 * FRAC_BITS + 2);
			assign g_c = sgn;
		end else begin : g_next
			assign t_c = t_s[k];
			assign p_c = p_s[k];
			assign q_c = q_s[k];
			assign n_c = n_s[k];
			assign x_c = x_s[k];
			assign g_c = g_s[k];
		end

		always_comb begin
			cand = p_c + (PW'(q_c) << (B + 1)) + (PW'(n_c) << (2 * B));
			take = (cand <= x_c);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				t_s[k+1] <= take ? (t_c | (NS'(1) << B)) : t_c;
				p_s[k+1] <= take ? cand : p_c;
				q_s[k+1] <= take ? (q_c + (QW'(n_c) << B)) : q_c;
				n_s[k+1] <= n_c;
				x_s[k+1] <= x_c;
				g_s[k+1] <= g_c;
			end
		end
	end

	assign t_out   = t_s[NS];
	assign sgn_out = g_s[NS];

endmodule

// ===== design/quaternion_arithmetic_unit.sv =====
`timescale 1ns / 1ps
`include "quaternion_arithmetic_unit_macros.svh"
// Throughput: one transaction per cycle while the skid stage is empty, set by the fully pipelined product
// lanes and by the square root chain of the normalize path, which resolves one result bit per stage.
// Reset: arst_n clears every pipeline valid bit and the valid flags of the output register and
// the skid stage at once; the data registers are not reset.
module quaternion_arithmetic_unit (
	input logic            clk,
	input logic            arst_n,
	qau_req_if.sink        req,
	qau_rsp_if.source      rsp
);
	import qau_pkg::*;

	// The whole pipeline moves together. It halts only when the skid stage holds a
	// result, so a result waiting in the output register does not stop new transactions.
	logic        en;
	logic [LAST:1] vld_s;

	// Stage 1: captured operands.
	logic [2:0] act_s1;
	word_t      a_s1 [4];
	word_t      b_s1 [4];
	word_t      f_s1;

	// Stages 2 to 5: operands and first-pass results travelling alongside the lanes.
	logic [2:0] act_s2, act_s3, act_s4, act_s5;
	word_t      a_s2 [4];
	word_t      a_s3 [4];
	word_t      a_s4 [4];
	word_t      a_s5 [4];
	word_t      b_s2 [4];
	word_t      b_s3 [4];
	logic [SQW-1:0] sq_s3 [4];
	word_t      w1_s4 [4];
	word_t      w1_s5 [4];
	logic [3:0] sat1_s4, sat1_s5;
	logic [NSQ_BITS-1:0] ns_s4, ns_s5;
	logic       nsat_s4, nsat_s5;
	logic       nz_s4, nz_s5;

	// First pass lanes: Hamilton product, rotation b*v, scaling or the squares of a.
	opnd_t      x1 [4][4];
	opnd_t      y1 [4][4];
	logic [3:0] n1 [4];
	prod_t      pr1_s2 [4][4];
	word_t      w1_s3 [4];
	logic [3:0] sat1_s3;
	sum_t       sum1_s3 [4];

	// Second pass lanes: (b*v) * conj(b) for rotation.
	opnd_t      x2 [4][4];
	opnd_t      y2 [4][4];
	logic [3:0] n2 [4];
	prod_t      pr2_s4 [4][4];
	word_t      w2_s5 [4];
	logic [3:0] sat2_s5;
	sum_t       sum2_s5 [4];

	logic [NS-1:0] tn [4];
	logic [3:0]    tsgn;

	stage_t     res5;
	stage_t     res_s [6:LAST];
	rsp_item_t  fin;

	rsp_item_t  out_q;
	logic       out_v_q;
	rsp_item_t  skid_q;
	logic       skid_v_q;

	assign en        = !skid_v_q;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAST-1:1], req.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= req.data.action;
			a_s1   <= '{req.data.a_w, req.data.a_x, req.data.a_y, req.data.a_z};
			b_s1   <= '{req.data.b_w, req.data.b_x, req.data.b_y, req.data.b_z};
			f_s1   <= req.data.factor;
		end
	end

	// Operand routing for the first pass, per action.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int k = 0; k < 4; k++) begin
				x1[i][k] = '0;
				y1[i][k] = '0;
			end
			n1[i] = '0;
			case (act_s1)
				ACT_MUL: begin
					for (int k = 0; k < 4; k++) begin
						x1[i][k] = sx(a_s1[QM_P[i][k]]);
						y1[i][k] = sx(b_s1[QM_Q[i][k]]);
					end
					n1[i] = QM_N[i];
				end
				ACT_ROT: begin
					// The vector enters as a quaternion with a zero scalar part.
					for (int k = 0; k < 4; k++) begin
						x1[i][k] = sx(b_s1[QM_P[i][k]]);
						y1[i][k] = (QM_Q[i][k] == 2'd0) ? '0 : sx(a_s1[QM_Q[i][k]]);
					end
					n1[i] = QM_N[i];
				end
				ACT_NORM, ACT_NSQ: begin
					for (int k = 0; k < 4; k++) begin
						x1[i][k] = sx(a_s1[k]);
						y1[i][k] = sx(a_s1[k]);
					end
				end
				ACT_SCALE: begin
					x1[i][0] = sx(f_s1);
					y1[i][0] = sx(a_s1[i]);
				end
				default: begin
				end
			endcase
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_pass1
		qau_lane u_lane (
			.clk     (clk),
			.en      (en),
			.x       (x1[i]),
			.y       (y1[i]),
			.neg     (n1[i]),
			.prod_s2 (pr1_s2[i]),
			.word_s3 (w1_s3[i]),
			.sat_s3  (sat1_s3[i]),
			.sum_s3  (sum1_s3[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s2 <= act_s1;
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			act_s3 <= act_s2;
			a_s3   <= a_s2;
			b_s3   <= b_s2;
			for (int k = 0; k < 4; k++) begin
				sq_s3[k] <= pr1_s2[0][k][SQW-1:0];
			end
		end
	end

	// Second pass: the rounded b*v times the exact conjugate of b.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int k = 0; k < 4; k++) begin
				x2[i][k] = sx(w1_s3[QM_P[i][k]]);
				y2[i][k] = (QM_Q[i][k] == 2'd0) ? sx(b_s3[0]) : -sx(b_s3[QM_Q[i][k]]);
			end
			n2[i] = QM_N[i];
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_pass2
		qau_lane u_lane (
			.clk     (clk),
			.en      (en),
			.x       (x2[i]),
			.y       (y2[i]),
			.neg     (n2[i]),
			.prod_s2 (pr2_s4[i]),
			.word_s3 (w2_s5[i]),
			.sat_s3  (sat2_s5[i]),
			.sum_s3  (sum2_s5[i])
		);
	end

	// Lane 0 of the first pass sums the four squares, which is the norm squared of a.
	logic [NW-1:0]   nsum;
	logic [NPAD-1:0] npad;
	assign nsum = sum1_s3[0][NW-1:0];
	assign npad = NPAD'(nsum);

	for (genvar i = 0; i < 4; i++) begin : g_norm
		qau_norm_lane u_norm (
			.clk     (clk),
			.en      (en),
			.nsum    (nsum),
			.sq      (sq_s3[i]),
			.sgn     (a_s3[i][WORD_BITS-1]),
			.t_out   (tn[i]),
			.sgn_out (tsgn[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s4  <= act_s3;
			a_s4    <= a_s3;
			w1_s4   <= w1_s3;
			sat1_s4 <= sat1_s3;
			nsat_s4 <= |npad[NPAD-1:NSQ_BITS];
			ns_s4   <= (|npad[NPAD-1:NSQ_BITS]) ? '1 : npad[NSQ_BITS-1:0];
			nz_s4   <= (nsum == '0);
			act_s5  <= act_s4;
			a_s5    <= a_s4;
			w1_s5   <= w1_s4;
			sat1_s5 <= sat1_s4;
			nsat_s5 <= nsat_s4;
			ns_s5   <= ns_s4;
			nz_s5   <= nz_s4;
		end
	end

	// Results of every action but normalize are settled here; normalize is only marked.
	logic  cneg_sat [4];
	word_t cneg     [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cneg_sat[i] = (a_s5[i] == WMIN);
			cneg[i]     = cneg_sat[i] ? WMAX : -a_s5[i];
		end
		res5 = '0;
		res5.item.status = ST_OK;
		case (act_s5)
			ACT_MUL, ACT_SCALE: begin
				res5.item.r_w    = w1_s5[0];
				res5.item.r_x    = w1_s5[1];
				res5.item.r_y    = w1_s5[2];
				res5.item.r_z    = w1_s5[3];
				res5.item.status = (|sat1_s5) ? ST_SAT : ST_OK;
			end
			ACT_ROT: begin
				res5.item.r_x    = w2_s5[1];
				res5.item.r_y    = w2_s5[2];
				res5.item.r_z    = w2_s5[3];
				res5.item.status = ((|sat1_s5) || (|sat2_s5[3:1])) ? ST_SAT : ST_OK;
			end
			ACT_CONJ: begin
				res5.item.r_w    = a_s5[0];
				res5.item.r_x    = cneg[1];
				res5.item.r_y    = cneg[2];
				res5.item.r_z    = cneg[3];
				res5.item.status = (cneg_sat[1] || cneg_sat[2] || cneg_sat[3]) ? ST_SAT : ST_OK;
			end
			ACT_NORM: begin
				res5.norm = 1'b1;
				res5.zero = nz_s5;
			end
			ACT_NSQ: begin
				res5.item.norm_sq = ns_s5;
				res5.item.status  = nsat_s5 ? ST_SAT : ST_OK;
			end
			default: begin
			end
		endcase
	end

	// Delay line that brings the short paths level with the end of the root chain.
	always_ff @(posedge clk) begin
		if (en) begin
			res_s[6] <= res5;
			for (int j = 7; j <= LAST; j++) begin
				res_s[j] <= res_s[j-1];
			end
		end
	end

	// Merge: round each normalized part to nearest, restore its sign and clamp.
	logic [NS:0] tinc [4];
	sum_t        qv   [4];
	wsat_t       qc   [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tinc[i] = (NS+1)'(tn[i]) + (NS+1)'(1);
			qv[i]   = $signed(SW'(tinc[i][NS:1]));
			if (tsgn[i]) begin
				qv[i] = -qv[i];
			end
			qc[i] = clamp_word(qv[i]);
		end
		fin = res_s[LAST].item;
		if (res_s[LAST].norm) begin
			fin = '0;
			if (res_s[LAST].zero) begin
				fin.status = ST_ZERO;
			end else begin
				fin.r_w    = qc[0].word;
				fin.r_x    = qc[1].word;
				fin.r_y    = qc[2].word;
				fin.r_z    = qc[3].word;
				fin.status = (qc[0].sat || qc[1].sat || qc[2].sat || qc[3].sat) ? ST_SAT : ST_OK;
			end
		end
	end

	// Output register with a skid stage behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (rsp.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || rsp.ready) begin
			out_v_q <= vld_s[LAST];
		end else if (vld_s[LAST]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (rsp.ready) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || rsp.ready) begin
			out_q <= fin;
		end else begin
			skid_q <= fin;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	// A held skid entry always has a result in front of it.
	`QAU_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q)
	// A finished result that meets a stalled output register lands in the skid stage.
	`QAU_ASSERT_NXT(a_skid_catch, vld_s[LAST] && en && out_v_q && !rsp.ready, skid_v_q)
	// Normalizing a zero quaternion leaves every result part at zero.
	`QAU_ASSERT_IMP(a_zero_norm, out_v_q && out_q.status == ST_ZERO, out_q.r_w == '0 && out_q.r_x == '0 && out_q.r_y == '0 && out_q.r_z == '0)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import qau_pkg::*;

	// Wide enough to hold every exact intermediate of the quaternion datapath.
	typedef logic signed [191:0] exact_t;

	logic clk;
	logic arst_n;

	qau_req_if req ();
	qau_rsp_if rsp ();

	quaternion_arithmetic_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// Transactions waiting to be offered, and results predicted for accepted transactions.
	req_item_t pending_items [$];
	rsp_item_t predicted_results [$];
	bit        offer_open;
	int        send_gap_pct;
	int        recv_stall_pct;
	int        fail_count;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic exact_t widen(input word_t v);
		exact_t r;
		r = v;
		return r;
	endfunction

	// Clamps an exact value to a word and flags saturation.
	function automatic word_t clamp_exact(input exact_t v, inout bit sat);
		if (v > widen(WMAX)) begin
			sat = 1'b1;
			return WMAX;
		end
		if (v < widen(WMIN)) begin
			sat = 1'b1;
			return WMIN;
		end
		return word_t'(v);
	endfunction

	// Rounds a product with twice the fraction bits to nearest, ties towards plus infinity.
	function automatic word_t round_product(input exact_t v, inout bit sat);
		exact_t t;
		t = (v + (exact_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		return clamp_exact(t, sat);
	endfunction

	// Exact Hamilton product p*q, lanes in the order w, x, y, z.
	function automatic void hamilton(input exact_t p [4], input exact_t q [4],
			output exact_t r [4]);
		r[0] = p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3];
		r[1] = p[1]*q[0] + p[0]*q[1] + p[2]*q[3] - p[3]*q[2];
		r[2] = p[2]*q[0] + p[0]*q[2] + p[3]*q[1] - p[1]*q[3];
		r[3] = p[3]*q[0] + p[0]*q[3] + p[1]*q[2] - p[2]*q[1];
	endfunction

	function automatic rsp_item_t quaternion_result(input req_item_t it);
		rsp_item_t      res;
		exact_t         a [4];
		exact_t         b [4];
		exact_t         t [4];
		exact_t         p [4];
		exact_t         nsq;
		logic [191:0]   mag;
		logic [191:0]   target;
		logic [191:0]   cand;
		logic [191:0]   root;
		word_t          r [4];
		bit             sat;
		bit             zero;
		sat = 1'b0;
		zero = 1'b0;
		a = '{widen(it.a_w), widen(it.a_x), widen(it.a_y), widen(it.a_z)};
		b = '{widen(it.b_w), widen(it.b_x), widen(it.b_y), widen(it.b_z)};
		r = '{default: '0};
		res = '0;
		nsq = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
		case (it.action)
			ACT_MUL: begin
				hamilton(a, b, p);
				for (int i = 0; i < 4; i++)
					r[i] = round_product(p[i], sat);
			end
			ACT_ROT: begin
				// b*v is rounded to words first; then times the exact conjugate of b.
				t = '{exact_t'(0), a[1], a[2], a[3]};
				hamilton(b, t, p);
				for (int i = 0; i < 4; i++)
					t[i] = widen(round_product(p[i], sat));
				for (int i = 1; i < 4; i++)
					b[i] = -b[i];
				hamilton(t, b, p);
				for (int i = 1; i < 4; i++)
					r[i] = round_product(p[i], sat);
			end
			ACT_CONJ: begin
				r[0] = it.a_w;
				for (int i = 1; i < 4; i++)
					r[i] = clamp_exact(-a[i], sat);
			end
			ACT_NORM: begin
				if (nsq == 0) begin
					zero = 1'b1;
				end else begin
					// Bitwise search for the largest root with root^2 * N <= 4 * a^2 * 2^(2F),
					// then one halving with rounding gives ties away from zero.
					for (int i = 0; i < 4; i++) begin
						mag = (a[i] < 0) ? -a[i] : a[i];
						target = (mag * mag) << (2 * FRAC_BITS + 2);
						root = '0;
						for (int k = FRAC_BITS + 1; k >= 0; k--) begin
							cand = root | (192'd1 << k);
							if (cand * cand * nsq <= target)
								root = cand;
						end
						root = (root + 1) >> 1;
						r[i] = clamp_exact((a[i] < 0) ? -exact_t'(root) : exact_t'(root), sat);
					end
				end
			end
			ACT_NSQ: begin
				if (nsq >= (exact_t'(1) <<< 64)) begin
					res.norm_sq = '1;
					sat = 1'b1;
				end else begin
					res.norm_sq = nsq[63:0];
				end
			end
			ACT_SCALE: begin
				for (int i = 0; i < 4; i++)
					r[i] = round_product(widen(it.factor) * a[i], sat);
			end
			default: begin
			end
		endcase
		res.r_w = r[0];
		res.r_x = r[1];
		res.r_y = r[2];
		res.r_z = r[3];
		res.status = zero ? ST_ZERO : (sat ? ST_SAT : ST_OK);
		return res;
	endfunction

	// Values around unity most often, with the extremes, zero and full-range words mixed in.
	function automatic word_t pick_word();
		case ($urandom_range(9))
			0: return WMIN;
			1: return WMAX;
			2: return '0;
			3, 4, 5, 6: return word_t'($signed($urandom_range(67108864)) - 33554432);
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic req_item_t make_item(input logic [2:0] act, input word_t aw,
			input word_t ax, input word_t ay, input word_t az, input word_t bw,
			input word_t bx, input word_t by, input word_t bz, input word_t f);
		req_item_t it;
		it.action = act;
		it.a_w = aw;
		it.a_x = ax;
		it.a_y = ay;
		it.a_z = az;
		it.b_w = bw;
		it.b_x = bx;
		it.b_y = by;
		it.b_z = bz;
		it.factor = f;
		return it;
	endfunction

	function automatic req_item_t random_item();
		logic [2:0] act;
		act = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
			: 3'($urandom_range(5));
		return make_item(act, pick_word(), pick_word(), pick_word(), pick_word(),
			pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
	endfunction

	// Driver: a new transaction is offered only once the previous one has been accepted.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data <= '0;
			offer_open = 1'b0;
		end else if (!offer_open) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
				req.data <= pending_items.pop_front();
				req.valid <= 1'b1;
				offer_open = 1'b1;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: predicts on each accepted request and checks each accepted result.
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				predicted_results.push_back(quaternion_result(req.data));
				offer_open = 1'b0;
			end
			if (rsp.valid && rsp.ready) begin
				if (predicted_results.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					want = predicted_results.pop_front();
					if (rsp.data.r_w !== want.r_w) begin
						$error("r_w expected %h actual %h", want.r_w, rsp.data.r_w);
						fail_count++;
					end
					if (rsp.data.r_x !== want.r_x) begin
						$error("r_x expected %h actual %h", want.r_x, rsp.data.r_x);
						fail_count++;
					end
					if (rsp.data.r_y !== want.r_y) begin
						$error("r_y expected %h actual %h", want.r_y, rsp.data.r_y);
						fail_count++;
					end
					if (rsp.data.r_z !== want.r_z) begin
						$error("r_z expected %h actual %h", want.r_z, rsp.data.r_z);
						fail_count++;
					end
					if (rsp.data.norm_sq !== want.norm_sq) begin
						$error("norm_sq expected %h actual %h", want.norm_sq,
							rsp.data.norm_sq);
						fail_count++;
					end
					if (rsp.data.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status,
							rsp.data.status);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		word_t one;
		one = word_t'(1) <<< FRAC_BITS;
		fail_count = 0;
		send_gap_pct = 11;
		recv_stall_pct = 56;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: each action, the extremes, and the special cases.
		pending_items.push_back(make_item(ACT_MUL, one, 0, 0, 0, 0, one, 0, 0, 0));
		pending_items.push_back(make_item(ACT_MUL, 0, one, 0, 0, 0, 0, one, 0, 0));
		pending_items.push_back(make_item(ACT_MUL, WMIN, WMIN, WMIN, WMIN,
			WMIN, WMIN, WMIN, WMIN, 0));
		pending_items.push_back(make_item(ACT_MUL, WMAX, WMAX, WMAX, WMAX,
			WMIN, WMAX, WMIN, WMAX, 0));
		pending_items.push_back(make_item(ACT_MUL, 1, -1, 1, -1, 32'h0080_0000, 1, 0, 0, 0));
		pending_items.push_back(make_item(ACT_ROT, 0, one, 0, 0, 32'h00B5_04F3, 0, 0,
			32'h00B5_04F3, 0));
		pending_items.push_back(make_item(ACT_ROT, WMAX, WMIN, WMAX, WMIN,
			WMIN, WMIN, WMAX, WMIN, 0));
		pending_items.push_back(make_item(ACT_CONJ, WMIN, WMIN, WMAX, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_CONJ, WMAX, 1, -1, one, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_NORM, 0, 0, 0, 0, WMAX, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_NORM, one, one, one, one, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_NORM, WMIN, WMIN, WMIN, WMIN, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_NORM, 0, 0, 0, 1, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_NORM, WMAX, -1, 0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_NSQ, WMIN, WMIN, WMIN, WMIN, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_NSQ, WMIN, WMIN, WMIN, WMAX, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_NSQ, one, -one, 0, 1, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_SCALE, WMAX, WMIN, one, -one, 0, 0, 0, 0,
			WMAX));
		pending_items.push_back(make_item(ACT_SCALE, WMIN, 1, -1, 0, 0, 0, 0, 0, WMIN));
		pending_items.push_back(make_item(ACT_SCALE, 1, 3, -1, -3, 0, 0, 0, 0,
			32'h0080_0000));
		pending_items.push_back(make_item(3'd6, WMAX, WMAX, WMAX, WMAX,
			WMAX, WMAX, WMAX, WMAX, WMAX));
		pending_items.push_back(make_item(3'd7, WMIN, WMIN, WMIN, WMIN,
			WMIN, WMIN, WMIN, WMIN, WMIN));

		// Three random phases with different idling on each side.
		for (int phase = 0; phase < 3; phase++) begin
			send_gap_pct = (phase == 0) ? 11 : ((phase == 1) ? 56 : 0);
			recv_stall_pct = (phase == 0) ? 56 : ((phase == 1) ? 11 : 0);
			repeat (615) pending_items.push_back(random_item());
			while (pending_items.size() > 0 || offer_open)
				@(posedge clk);
		end

		while (predicted_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#400000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
